### src/ric_pkg.sv
// Shared types and constants for the reference-counted inode slot cache.
// No dependencies; imported by ric_ctrl, ric_dpath and the top level.
package ric_pkg;

  localparam int unsigned RefsW   = 16;
  localparam int unsigned DevW    = 8;
  localparam int unsigned InodeW  = 16;
  localparam int unsigned LinksW  = 16;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned TagW    = DevW + InodeW;
  localparam logic [RefsW-1:0] RefsMax = {RefsW{1'b1}};

  typedef enum logic [1:0] {
    REQ_GET  = 2'd0,
    REQ_DUP  = 2'd1,
    REQ_FILL = 2'd2,
    REQ_PUT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOREF = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_OP,
    S_SCAN,
    S_HIT_RD,
    S_HIT_WR,
    S_CLAIM
  } state_e;

  // Final update performed by the datapath; each one but ACT_NONE also issues a response.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_NOREF,
    ACT_SLOT,
    ACT_HIT,
    ACT_CLAIM
  } act_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [DevW-1:0]    device_id;
    logic [InodeW-1:0]  inode_number;
    logic [SlotW-1:0]   slot_index;
    logic [LinksW-1:0]  link_count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot_out;
    logic               hit;
    logic               was_valid;
    logic               free_on_disk;
  } rsp_t;

  typedef struct packed {
    logic load;       // latch request, restart scan
    logic step;       // advance tag sweep
    logic set_hit;    // target <= matching slot
    logic set_empty;  // target <= lowest free slot
    logic rd;         // read refs/links at target
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic in_get;     // incoming request is a get
    logic addr_ok;    // latched slot index in range and referenced
    logic match;      // compare stage hit a live slot
    logic exhausted;  // every slot compared, no match
  } sts_t;

endpackage

### src/ric_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents undefined until written.
module ric_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ric_ctrl.sv
// Controller FSM: sequences scan, read and update steps for each request.
// Depends on ric_pkg (state, command and status types).
module ric_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ric_pkg::sts_t sts_i,
  output ric_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import ric_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, act: ACT_NONE};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_get ? S_SCAN : S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.addr_ok) begin
          cmd_o.rd = 1'b1;
          state_d  = S_OP;
        end else begin
          cmd_o.act = ACT_NOREF;
          state_d   = S_IDLE;
        end
      end
      S_OP: begin
        cmd_o.act = ACT_SLOT;
        state_d   = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = S_HIT_RD;
        end else if (sts_i.exhausted) begin
          cmd_o.set_empty = 1'b1;
          state_d         = S_CLAIM;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_HIT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_HIT_WR;
      end
      S_HIT_WR: begin
        cmd_o.act = ACT_HIT;
        state_d   = S_IDLE;
      end
      S_CLAIM: begin
        cmd_o.act = ACT_CLAIM;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### src/ric_dpath.sv
// Datapath: slot tables (tag, refs, links RAMs plus live/valid flops),
// tag sweep, response register. Depends on ric_pkg and ric_ram.
module ric_dpath #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ric_pkg::req_t req_i,
  input  ric_pkg::cmd_t cmd_i,
  output ric_pkg::sts_t sts_o,
  output logic          done_o,
  output ric_pkg::rsp_t rsp_o
);
  import ric_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned AW   = (CntW > SlotW) ? CntW : SlotW;

  req_t            req_q;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            empty_found_q, empty_found_d;
  logic [IdxW-1:0] empty_idx_q, empty_idx_d;
  logic [IdxW-1:0] tgt_q, tgt_d;
  logic [SLOTS-1:0] live_q, live_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  rsp_t            rsp_q, rsp_d;
  logic            done_q, done_d;

  logic [AW-1:0]   in_idx_ext, req_idx_ext, tgt_ext;
  logic            req_in_range;

  logic            tag_we, tag_re;
  logic [TagW-1:0] tag_rdata;
  logic            refs_we;
  logic [RefsW-1:0] refs_wdata, refs_rdata;
  logic            links_we;
  logic [LinksW-1:0] links_rdata;

  assign in_idx_ext   = AW'(req_i.slot_index);
  assign req_idx_ext  = AW'(req_q.slot_index);
  assign tgt_ext      = AW'(tgt_q);
  assign req_in_range = (req_idx_ext < AW'(SLOTS));

  assign tag_re = cmd_i.step && (scan_q < CntW'(SLOTS));

  // status to controller
  assign sts_o.in_get    = (req_i.req_type == REQ_GET);
  assign sts_o.addr_ok   = req_in_range && live_q[req_idx_ext[IdxW-1:0]];
  assign sts_o.match     = cmp_vld_q && live_q[cmp_idx_q] &&
                           (tag_rdata == {req_q.device_id, req_q.inode_number});
  assign sts_o.exhausted = !cmp_vld_q && (scan_q == CntW'(SLOTS));

  always_comb begin
    scan_d        = scan_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    tgt_d         = tgt_q;
    live_d        = live_q;
    valid_d       = valid_q;
    rsp_d         = rsp_q;
    done_d        = 1'b0;
    tag_we        = 1'b0;
    refs_we       = 1'b0;
    refs_wdata    = refs_rdata;
    links_we      = 1'b0;

    // lowest free slot, tracked at the compare stage of the sweep
    if (cmp_vld_q && !live_q[cmp_idx_q] && !empty_found_q) begin
      empty_found_d = 1'b1;
      empty_idx_d   = cmp_idx_q;
    end

    if (cmd_i.load) begin
      scan_d        = '0;
      empty_found_d = 1'b0;
      tgt_d         = in_idx_ext[IdxW-1:0];
    end
    if (tag_re) begin
      cmp_vld_d = 1'b1;
      cmp_idx_d = scan_q[IdxW-1:0];
      scan_d    = scan_q + CntW'(1);
    end
    if (cmd_i.set_hit) begin
      tgt_d = cmp_idx_q;
    end
    if (cmd_i.set_empty) begin
      tgt_d = empty_idx_q;
    end

    case (cmd_i.act)
      ACT_NOREF: begin
        done_d             = 1'b1;
        rsp_d.status       = STAT_NOREF;
        rsp_d.slot_out     = req_q.slot_index;
        rsp_d.hit          = 1'b0;
        rsp_d.was_valid    = req_in_range && valid_q[req_idx_ext[IdxW-1:0]];
        rsp_d.free_on_disk = 1'b0;
      end
      ACT_HIT: begin
        done_d             = 1'b1;
        rsp_d.slot_out     = tgt_ext[SlotW-1:0];
        rsp_d.hit          = 1'b1;
        rsp_d.was_valid    = valid_q[tgt_q];
        rsp_d.free_on_disk = 1'b0;
        if (refs_rdata == RefsMax) begin
          rsp_d.status = STAT_SAT;
        end else begin
          rsp_d.status = STAT_OK;
          refs_we      = 1'b1;
          refs_wdata   = refs_rdata + RefsW'(1);
        end
      end
      ACT_CLAIM: begin
        done_d             = 1'b1;
        rsp_d.hit          = 1'b0;
        rsp_d.free_on_disk = 1'b0;
        if (empty_found_q) begin
          rsp_d.status    = STAT_OK;
          rsp_d.slot_out  = tgt_ext[SlotW-1:0];
          rsp_d.was_valid = valid_q[tgt_q];
          tag_we          = 1'b1;
          refs_we         = 1'b1;
          refs_wdata      = RefsW'(1);
          live_d[tgt_q]   = 1'b1;
          valid_d[tgt_q]  = 1'b0;
        end else begin
          rsp_d.status    = STAT_FULL;
          rsp_d.slot_out  = '0;
          rsp_d.was_valid = 1'b0;
        end
      end
      ACT_SLOT: begin
        done_d             = 1'b1;
        rsp_d.status       = STAT_OK;
        rsp_d.slot_out     = req_q.slot_index;
        rsp_d.hit          = 1'b0;
        rsp_d.was_valid    = valid_q[tgt_q];
        rsp_d.free_on_disk = 1'b0;
        case (req_q.req_type)
          REQ_DUP: begin
            if (refs_rdata == RefsMax) begin
              rsp_d.status = STAT_SAT;
            end else begin
              refs_we    = 1'b1;
              refs_wdata = refs_rdata + RefsW'(1);
            end
          end
          REQ_FILL: begin
            valid_d[tgt_q] = 1'b1;
            links_we       = 1'b1;
          end
          REQ_PUT: begin
            refs_we    = 1'b1;
            refs_wdata = refs_rdata - RefsW'(1);
            if (refs_rdata == RefsW'(1)) begin
              live_d[tgt_q] = 1'b0;
              // last reference of a loaded, unlinked inode
              if (valid_q[tgt_q] && (links_rdata == '0)) begin
                valid_d[tgt_q]     = 1'b0;
                rsp_d.free_on_disk = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q        <= '0;
      cmp_vld_q     <= 1'b0;
      empty_found_q <= 1'b0;
      live_q        <= '0;
      valid_q       <= '0;
      done_q        <= 1'b0;
    end else begin
      scan_q        <= scan_d;
      cmp_vld_q     <= cmp_vld_d;
      empty_found_q <= empty_found_d;
      live_q        <= live_d;
      valid_q       <= valid_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    cmp_idx_q   <= cmp_idx_d;
    empty_idx_q <= empty_idx_d;
    tgt_q       <= tgt_d;
    rsp_q       <= rsp_d;
  end

  ric_ram #(.Width(TagW), .Depth(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tgt_q),
    .wdata_i ({req_q.device_id, req_q.inode_number}),
    .re_i    (tag_re),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (tag_rdata)
  );

  ric_ram #(.Width(RefsW), .Depth(SLOTS)) u_refs_ram (
    .clk_i   (clk_i),
    .we_i    (refs_we),
    .waddr_i (tgt_q),
    .wdata_i (refs_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (tgt_q),
    .rdata_o (refs_rdata)
  );

  ric_ram #(.Width(LinksW), .Depth(SLOTS)) u_links_ram (
    .clk_i   (clk_i),
    .we_i    (links_we),
    .waddr_i (tgt_q),
    .wdata_i (req_q.link_count),
    .re_i    (cmd_i.rd),
    .raddr_i (tgt_q),
    .rdata_o (links_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### src/refcounted_inode_slot_cache.sv
// Top level of the reference-counted inode slot cache.
// Depends on ric_pkg, ric_ctrl, ric_dpath (which uses ric_ram).
//
// A request is taken on a rising edge with start_i high and busy_o low.
// Each request yields exactly one response: rsp_o is valid for the single
// cycle in which done_o is high and must be captured then, since the
// receiver cannot stall the block. busy_o stays high from the edge of
// acceptance until the response has been registered; a new request may be
// issued in the same cycle done_o is shown.
//
// Steps per request:
//   dup / fill / put : accept, refs/links RAM read, update;
//                      only accept and check when the slot is
//                      unreferenced or out of range.
//   get              : accept, then tag sweep until a match, a miss or a
//                      full table, then update.
// A get's duration is set by the tag sweep: device/inode tags sit in a
// single-read-port RAM, so one slot is compared per cycle, lowest first,
// and the lowest free slot is recorded on the way. A hit stops the sweep
// early. The reference count sits in its own RAM and is updated by a
// read-modify-write after a sweep that hits, or set to one on a claim.
//
// Per-slot "live" (refs > 0) and "valid" marks are flip-flops cleared by
// reset, so no clearing pass is needed; tag and link contents are only
// ever used for slots that have been written.
//
// Status codes: ok, no free slot (get on a full table), no reference
// (dup/fill/put on an unreferenced or out-of-range slot), saturated count.
module refcounted_inode_slot_cache #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ric_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output ric_pkg::rsp_t rsp_o
);
  import ric_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ric_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ric_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### bench/testbench.sv
// Self-checking bench for the reference-counted inode slot cache.
// Depends on ric_pkg and the refcounted_inode_slot_cache RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ric_pkg::*;

  localparam int unsigned NumSlots    = 64;
  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 5;
  // Slowest request is a get that compares every slot. Add the
  // longest plausible run of idle cycles at 78% and take that many times over.
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned TailCycles  = NumSlots + 8;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned DrainBudget = 400;
  localparam int unsigned MaxPrinted  = 50;

  // Shadow copy of the slot table plus the queue of responses still owed.
  class slot_cache_scoreboard;
    rsp_t              expected_q[$];
    int unsigned       errors;
    logic [DevW-1:0]   dev_tag   [NumSlots];
    logic [InodeW-1:0] inode_tag [NumSlots];
    logic [RefsW-1:0]  refs      [NumSlots];
    logic              valid     [NumSlots];
    logic [LinksW-1:0] links     [NumSlots];

    function new();
      errors = 0;
      foreach (refs[k]) begin
        dev_tag[k]   = '0;
        inode_tag[k] = '0;
        refs[k]      = '0;
        valid[k]     = 1'b0;
        links[k]     = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Applies one request to the shadow table and returns the response it owes.
    function rsp_t apply_request(req_t r);
      rsp_t        o;
      int          free_slot;
      bit          found;
      bit          release_slot;
      int unsigned idx;
      o         = '0;
      o.status  = STAT_OK;
      free_slot = -1;
      found     = 1'b0;
      if (r.req_type == REQ_GET) begin
        // Lowest live match wins; lowest free slot is remembered on the way.
        for (int unsigned k = 0; k < NumSlots && !found; k++) begin
          if (refs[k] != 0 && dev_tag[k] == r.device_id && inode_tag[k] == r.inode_number) begin
            found       = 1'b1;
            o.hit       = 1'b1;
            o.slot_out  = SlotW'(k);
            o.was_valid = valid[k];
            if (refs[k] == RefsMax) o.status = STAT_SAT;
            else refs[k]++;
          end else if (free_slot < 0 && refs[k] == 0) begin
            free_slot = k;
          end
        end
        if (!found) begin
          if (free_slot < 0) begin
            o.status = STAT_FULL;
          end else begin
            o.slot_out           = SlotW'(free_slot);
            o.was_valid          = valid[free_slot];
            dev_tag[free_slot]   = r.device_id;
            inode_tag[free_slot] = r.inode_number;
            refs[free_slot]      = RefsW'(1);
            valid[free_slot]     = 1'b0;
          end
        end
        return o;
      end
      idx         = 32'(r.slot_index);
      o.slot_out  = r.slot_index;
      if (idx >= NumSlots) begin
        o.status = STAT_NOREF;
        return o;
      end
      o.was_valid = valid[idx];
      if (refs[idx] == 0) begin
        o.status = STAT_NOREF;
        return o;
      end
      case (r.req_type)
        REQ_DUP: begin
          if (refs[idx] == RefsMax) o.status = STAT_SAT;
          else refs[idx]++;
        end
        REQ_FILL: begin
          valid[idx] = 1'b1;
          links[idx] = r.link_count;
        end
        default: begin
          // last reference of a loaded, unlinked inode goes back to disk
          release_slot   = refs[idx] == 1 && valid[idx] && links[idx] == 0;
          if (release_slot) valid[idx] = 1'b0;
          refs[idx]--;
          o.free_on_disk = release_slot;
        end
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(apply_request(r));
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("response with no request pending: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.slot_out !== want.slot_out)
        report($sformatf("slot_out got %0d want %0d", got.slot_out, want.slot_out));
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.was_valid !== want.was_valid)
        report($sformatf("was_valid got %b want %b", got.was_valid, want.was_valid));
      if (got.free_on_disk !== want.free_on_disk)
        report($sformatf("free_on_disk got %b want %b", got.free_on_disk, want.free_on_disk));
    endtask

    function int unsigned live_count();
      int unsigned n;
      n = 0;
      foreach (refs[k]) if (refs[k] != 0) n++;
      return n;
    endfunction

    // Random referenced slot, or any slot when the table is empty.
    function int unsigned pick_live();
      int unsigned live[$];
      foreach (refs[k]) if (refs[k] != 0) live.push_back(k);
      if (live.size() == 0) return $urandom_range(NumSlots - 1);
      return live[$urandom_range(live.size() - 1)];
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  slot_cache_scoreboard sb = new();

  int unsigned n_sent;        // requests seen accepted by the driver
  int unsigned n_noted;       // requests entered into the shadow table
  int unsigned stall_cycles;
  int          idle_pct;      // chance per cycle that the sender holds off

  always #(HalfPeriod) clk_i = ~clk_i;

  refcounted_inode_slot_cache #(.SLOTS(NumSlots)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Monitor: one process checks the response, then notes the request taken
  // on the same edge, so the two never race. Also runs the stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start_i && !busy_o) begin
        sb.note_request(req_i);
        n_noted++;
      end
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Fields a request does not use are still randomized, so their bits toggle.
  function automatic req_t get_req(logic [DevW-1:0] dev, logic [InodeW-1:0] ino);
    req_t r;
    r.req_type     = REQ_GET;
    r.device_id    = dev;
    r.inode_number = ino;
    r.slot_index   = SlotW'($urandom);
    r.link_count   = LinksW'($urandom);
    return r;
  endfunction

  function automatic req_t slot_req(req_type_e t, int unsigned k, logic [LinksW-1:0] lc);
    req_t r;
    r.req_type     = t;
    r.device_id    = DevW'($urandom);
    r.inode_number = InodeW'($urandom);
    r.slot_index   = SlotW'(k);
    r.link_count   = lc;
    return r;
  endfunction

  // Zero links often, so puts can free the inode on disk.
  function automatic logic [LinksW-1:0] pick_links();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return '0;
    if (p < 60) return '1;
    return LinksW'($urandom);
  endfunction

  // Small tag pool so gets keep hitting live slots.
  function automatic logic [DevW-1:0] pool_dev();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return 8'h5a;
      default: return 8'ha5;
    endcase
  endfunction

  function automatic logic [InodeW-1:0] pool_inode();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 16'h0001;
      3:       return 16'h8000;
      4:       return 16'h1234;
      default: return 16'hedcb;
    endcase
  endfunction

  // Drive one request, holding start high until busy drops, then wait for the
  // monitor to enter it so the generator sees an up-to-date table.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    n_sent++;
    wait (n_noted == n_sent);
  endtask

  // Claim slots with fresh tags until none is free, then two gets on the full table.
  task automatic fill_table();
    int unsigned k;
    while (sb.live_count() != NumSlots)
      send_request(get_req(DevW'($urandom), InodeW'($urandom)));
    send_request(get_req(DevW'($urandom), InodeW'($urandom)));
    k = sb.pick_live();
    send_request(get_req(sb.dev_tag[k], sb.inode_tag[k]));
  endtask

  // Release references, loading some slots first so their last put can free them.
  task automatic drain_table();
    int unsigned k;
    int unsigned budget;
    budget = 0;
    while (sb.live_count() != 0 && budget < DrainBudget) begin
      k = sb.pick_live();
      if (!sb.valid[k] && $urandom_range(1)) send_request(slot_req(REQ_FILL, k, pick_links()));
      else send_request(slot_req(REQ_PUT, k, pick_links()));
      budget++;
    end
  endtask

  task automatic mixed_sequence(int unsigned len);
    int unsigned op;
    int unsigned k;
    for (int unsigned i = 0; i < len; i++) begin
      op = $urandom_range(99);
      k  = ($urandom_range(99) < 85) ? sb.pick_live() : $urandom_range(NumSlots - 1);
      if (op < 35) begin
        if ($urandom_range(99) < 70) send_request(get_req(pool_dev(), pool_inode()));
        else send_request(get_req(DevW'($urandom), InodeW'($urandom)));
      end else if (op < 50) begin
        send_request(slot_req(REQ_DUP, k, pick_links()));
      end else if (op < 72) begin
        send_request(slot_req(REQ_FILL, k, pick_links()));
      end else begin
        send_request(slot_req(REQ_PUT, k, pick_links()));
      end
    end
  endtask

  initial begin
    int unsigned rand_start;
    int unsigned pick;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    req_i        <= '0;
    n_sent       = 0;
    n_noted      = 0;
    stall_cycles = 0;
    idle_pct     = 23;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tag extremes, partial tag matches, unreferenced slots,
    // stale valid mark on a claimed slot, release to disk.
    send_request(get_req('0, '0));                  // claim slot 0
    send_request(get_req('0, '0));                  // hit slot 0
    send_request(get_req('1, '1));                  // claim slot 1
    send_request(get_req('0, '1));                  // device matches only
    send_request(get_req('1, '0));                  // inode matches only
    send_request(slot_req(REQ_DUP, NumSlots - 1, '0));   // no reference
    send_request(slot_req(REQ_FILL, NumSlots - 1, '1));
    send_request(slot_req(REQ_PUT, NumSlots - 1, '0));
    send_request(slot_req(REQ_DUP, 1, '0));
    send_request(slot_req(REQ_FILL, 0, '0));
    send_request(slot_req(REQ_FILL, 1, '1));
    send_request(slot_req(REQ_PUT, 1, '0));
    send_request(slot_req(REQ_PUT, 1, '0));         // zero refs, still valid
    send_request(slot_req(REQ_DUP, 1, '0));         // no reference, was valid
    send_request(slot_req(REQ_PUT, 0, '0));
    send_request(slot_req(REQ_PUT, 0, '0));         // unlinked: free on disk
    send_request(get_req(8'h01, 16'h0001));         // reclaims slot 0
    send_request(get_req(8'h02, 16'h0002));         // reclaims stale-valid slot 1
    send_request(slot_req(REQ_FILL, 2, '0));
    send_request(slot_req(REQ_FILL, 2, 16'h1234));  // referenced: links overwritten, nonzero
    send_request(slot_req(REQ_PUT, 2, '0));         // last reference, but linked: no release
    send_request(slot_req(REQ_PUT, 1, '0));         // not loaded: no release
    fill_table();
    drain_table();

    // Random: mostly mixed traffic on live slots, with table fill and drain
    // bursts; sender idling 23%, then 78%, then none.
    rand_start = n_sent;
    while (n_sent - rand_start < RandomItems) begin
      if (n_sent - rand_start < RandomItems / 3) idle_pct = 23;
      else if (n_sent - rand_start < 2 * RandomItems / 3) idle_pct = 78;
      else idle_pct = 0;
      pick = $urandom_range(99);
      if (pick < 7) fill_table();
      else if (pick < 14) drain_table();
      else mixed_sequence($urandom_range(30, 10));
    end
    start_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/ric_pkg.sv
src/ric_ram.sv
src/ric_ctrl.sv
src/ric_dpath.sv
src/refcounted_inode_slot_cache.sv
bench/testbench.sv
